// ===== src/bip_buffer_region_controller_assert.svh =====
// Assertion macros for the bip buffer region controller
`ifndef BIP_BUFFER_REGION_CONTROLLER_ASSERT_SVH
`define BIP_BUFFER_REGION_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BIPBRC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bipbrc: same-cycle check failed");

// next-cycle implication
`define BIPBRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bipbrc: next-cycle check failed");

`else

`define BIPBRC_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BIPBRC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/bipbrc_pkg.sv =====
// Shared types and constants of the bip buffer region controller
`default_nettype none

package bipbrc_pkg;

   localparam int OP_W               = 3;
   localparam int SIZE_W             = 16;
   localparam int STATUS_W           = 2;
   localparam int OFFSET_OUT_W       = 16;
   localparam int CAP_W              = 16;
   localparam int OFFSET_BITS_DEFAULT = 16;
   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'hFFFF;

   // register word index in the CSR space
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [OP_W-1:0] {
      OP_STAGE_READ  = 3'd0,
      OP_COMMIT_READ = 3'd1,
      OP_STAGE_WRITE = 3'd2,
      OP_COMMIT_WRITE = 3'd3,
      OP_CLEAR       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_MISUSE  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== src/bipbrc_if.sv =====
// Request and response channel interfaces
`default_nettype none

interface bipbrc_req_if;
   logic                            valid;
   logic                            ready;
   logic [bipbrc_pkg::OP_W-1:0]     op;
   logic [bipbrc_pkg::SIZE_W-1:0]   size;

   modport source (output valid, output op, output size, input ready);
   modport sink   (input valid, input op, input size, output ready);
endinterface

interface bipbrc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bipbrc_pkg::STATUS_W-1:0]     status;
   logic [bipbrc_pkg::OFFSET_OUT_W-1:0] offset;

   modport source (output valid, output status, output offset, input ready);
   modport sink   (input valid, input status, input offset, output ready);
endinterface

`default_nettype wire

// ===== src/bipbrc_ctrl.sv =====
// Transaction sequencer: take request, then evaluate once the response slot is free
`default_nettype none

module bipbrc_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  bipbrc_pkg::dp_stat_type  status,
   output bipbrc_pkg::ctrl_cmd_type cmd
);
   import bipbrc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // nothing is taken while reset is held
            req_ready = ~reset;
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold here while the previous response is still unclaimed
            if (status.rsp_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bipbrc_datapath.sv =====
// Region pointers, pending sizes, op evaluation and response register
`default_nettype none

`include "bip_buffer_region_controller_assert.svh"

module bipbrc_datapath #(
   parameter int OFFSET_BITS = bipbrc_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  bipbrc_pkg::ctrl_cmd_type             cmd,
   output bipbrc_pkg::dp_stat_type              status,
   input  wire [bipbrc_pkg::OP_W-1:0]           req_op,
   input  wire [bipbrc_pkg::SIZE_W-1:0]         req_size,
   input  wire [bipbrc_pkg::CAP_W-1:0]          capacity,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [bipbrc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bipbrc_pkg::OFFSET_OUT_W-1:0]  rsp_offset
);
   import bipbrc_pkg::*;

   localparam int PW = OFFSET_BITS;
   // compare width: wide enough for any pointer, size or capacity, plus a carry
   localparam int CW = ((PW > SIZE_W) ? PW : SIZE_W) + 1;

   // latched request
   op_type              op_ff;
   logic [SIZE_W-1:0]   size_ff;

   // region state
   logic [PW-1:0]       beg0_ff, beg0_in, beg1_ff, beg1_in;
   logic [PW-1:0]       end0_ff, end0_in, end1_ff, end1_in;
   logic                rd_sel_ff, rd_sel_in;
   logic                wr_sel_ff, wr_sel_in;
   logic [SIZE_W-1:0]   rd_pend_ff, rd_pend_in;
   logic [SIZE_W-1:0]   wr_pend_ff, wr_pend_in;

   // response
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [OFFSET_OUT_W-1:0] rsp_offset_ff;

   status_type          status_c;
   logic [CW-1:0]       off_c;

   logic [PW-1:0]       b_r, e_r, e_w, e_nx;
   logic [CW-1:0]       b_rx, e_rx, e_wx, e_nxx, size_x, cap_x, cap_raw_x, mask_x;
   logic [CW-1:0]       avail_x, e_minus_b, cap_minus_we, avail_minus_we;
   logic [CW-1:0]       beg_sum, end_sum;
   logic                size_nz, rd_pend_nz, wr_pend_nz;

   // operand selection and extension
   always_comb begin
      b_r  = rd_sel_ff ? beg1_ff : beg0_ff;
      e_r  = rd_sel_ff ? end1_ff : end0_ff;
      e_nx = rd_sel_ff ? end0_ff : end1_ff;
      e_w  = wr_sel_ff ? end1_ff : end0_ff;

      b_rx      = {{(CW-PW){1'b0}}, b_r};
      e_rx      = {{(CW-PW){1'b0}}, e_r};
      e_nxx     = {{(CW-PW){1'b0}}, e_nx};
      e_wx      = {{(CW-PW){1'b0}}, e_w};
      size_x    = {{(CW-SIZE_W){1'b0}}, size_ff};
      cap_raw_x = {{(CW-CAP_W){1'b0}}, capacity};
      mask_x    = {{(CW-PW){1'b0}}, {PW{1'b1}}};
      cap_x     = (cap_raw_x < mask_x) ? cap_raw_x : mask_x;

      avail_x        = (b_r == e_r) ? cap_x : b_rx;
      e_minus_b      = e_rx - b_rx;
      cap_minus_we   = cap_x - e_wx;
      avail_minus_we = avail_x - e_wx;
      beg_sum        = b_rx + size_x;
      end_sum        = e_wx + size_x;

      size_nz    = (size_ff != '0);
      rd_pend_nz = (rd_pend_ff != '0);
      wr_pend_nz = (wr_pend_ff != '0);
   end

   // op evaluation
   always_comb begin
      beg0_in    = beg0_ff;
      beg1_in    = beg1_ff;
      end0_in    = end0_ff;
      end1_in    = end1_ff;
      rd_sel_in  = rd_sel_ff;
      wr_sel_in  = wr_sel_ff;
      rd_pend_in = rd_pend_ff;
      wr_pend_in = wr_pend_ff;
      status_c   = ST_MISUSE;
      off_c      = '0;
      case (op_ff)
         OP_STAGE_READ: begin
            if (size_nz && !rd_pend_nz) begin
               if (b_r != e_r) begin
                  if ((b_rx > e_rx) || (e_minus_b < size_x)) begin
                     status_c = ST_REFUSED;
                  end else begin
                     rd_pend_in = size_ff;
                     off_c      = b_rx;
                     status_c   = ST_OK;
                  end
               end else if ((rd_sel_ff == wr_sel_ff) || (e_nxx < size_x)) begin
                  status_c = ST_REFUSED;
               end else begin
                  // current region drained: follow the writer into the other one
                  if (rd_sel_ff) begin
                     beg0_in = '0;
                  end else begin
                     beg1_in = '0;
                  end
                  rd_sel_in  = ~rd_sel_ff;
                  rd_pend_in = size_ff;
                  status_c   = ST_OK;
               end
            end
         end
         OP_COMMIT_READ: begin
            if (size_nz && rd_pend_nz && (size_ff <= rd_pend_ff)) begin
               if (rd_sel_ff) begin
                  beg1_in = beg_sum[PW-1:0];
               end else begin
                  beg0_in = beg_sum[PW-1:0];
               end
               rd_pend_in = '0;
               status_c   = ST_OK;
            end
         end
         OP_STAGE_WRITE: begin
            if (size_nz && !wr_pend_nz) begin
               if (rd_sel_ff == wr_sel_ff) begin
                  if ((e_wx <= cap_x) && (cap_minus_we >= size_x)) begin
                     wr_pend_in = size_ff;
                     off_c      = e_wx;
                     status_c   = ST_OK;
                  end else if (avail_x < size_x) begin
                     status_c = ST_REFUSED;
                  end else begin
                     // no room at the tail: wrap into the other region at zero
                     if (wr_sel_ff) begin
                        end0_in = '0;
                     end else begin
                        end1_in = '0;
                     end
                     wr_sel_in  = ~wr_sel_ff;
                     wr_pend_in = size_ff;
                     status_c   = ST_OK;
                  end
               end else if ((avail_x < e_wx) || (avail_minus_we < size_x)) begin
                  status_c = ST_REFUSED;
               end else begin
                  wr_pend_in = size_ff;
                  off_c      = e_wx;
                  status_c   = ST_OK;
               end
            end
         end
         OP_COMMIT_WRITE: begin
            if (size_nz && wr_pend_nz && (size_ff <= wr_pend_ff)) begin
               if (wr_sel_ff) begin
                  end1_in = end_sum[PW-1:0];
               end else begin
                  end0_in = end_sum[PW-1:0];
               end
               wr_pend_in = '0;
               status_c   = ST_OK;
            end
         end
         OP_CLEAR: begin
            beg0_in    = '0;
            beg1_in    = '0;
            end0_in    = '0;
            end1_in    = '0;
            rd_sel_in  = 1'b0;
            wr_sel_in  = 1'b0;
            rd_pend_in = '0;
            wr_pend_in = '0;
            status_c   = ST_OK;
         end
         default: begin
            status_c = ST_MISUSE;
         end
      endcase
   end

   assign rsp_valid_in    = cmd.execute | (rsp_valid_ff & ~rsp_ready);
   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_op);
         size_ff <= req_size;
      end
      if (cmd.execute) begin
         rsp_status_ff <= status_c;
         rsp_offset_ff <= off_c[OFFSET_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beg0_ff      <= '0;
         beg1_ff      <= '0;
         end0_ff      <= '0;
         end1_ff      <= '0;
         rd_sel_ff    <= 1'b0;
         wr_sel_ff    <= 1'b0;
         rd_pend_ff   <= '0;
         wr_pend_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.execute) begin
            beg0_ff    <= beg0_in;
            beg1_ff    <= beg1_in;
            end0_ff    <= end0_in;
            end1_ff    <= end1_in;
            rd_sel_ff  <= rd_sel_in;
            wr_sel_ff  <= wr_sel_in;
            rd_pend_ff <= rd_pend_in;
            wr_pend_ff <= wr_pend_in;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_offset_ff;

   `BIPBRC_ASSERT_NEXT(a_reject_keeps_state, clock, reset, cmd.execute && (status_c != ST_OK), $stable(beg0_ff) && $stable(beg1_ff) && $stable(end0_ff) && $stable(end1_ff) && $stable(rd_sel_ff) && $stable(wr_sel_ff) && $stable(rd_pend_ff) && $stable(wr_pend_ff))
   `BIPBRC_ASSERT_NEXT(a_read_grant_pends, clock, reset, cmd.execute && (op_ff == OP_STAGE_READ) && (status_c == ST_OK), rd_pend_ff != '0)
   `BIPBRC_ASSERT_NEXT(a_region_sel_quiet, clock, reset, !cmd.execute, $stable(rd_sel_ff) && $stable(wr_sel_ff))
   `BIPBRC_ASSERT_IMPL(a_no_offset_unless_ok, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_offset_ff == '0)

endmodule

`default_nettype wire

// ===== src/bip_buffer_region_controller.sv =====
// Top level of the bip buffer region controller
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | valid / ready      | op[2:0], size[15:0]
//  rsp     | out       | valid / ready      | status[1:0], offset[15:0]
//  csr     | in        | APB psel / penable | capacity at word 0 (16 bit)
//
// Each transaction first captures the request, then evaluates
// it against the region pointers and loads the response register.
// The next request is taken in the cycle after evaluation, while the response
// may still be waiting; a full response register holds evaluation back.
// Reset (synchronous) empties both regions, selects region 0, sets capacity to 65535.
// APB writes complete without wait states, with pready tied high.
`default_nettype none

module bip_buffer_region_controller #(
   parameter int OFFSET_BITS = bipbrc_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   bipbrc_req_if.sink                           req,
   bipbrc_rsp_if.source                         rsp,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire [bipbrc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire [bipbrc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bipbrc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                 pready
);
   import bipbrc_pkg::*;

   ctrl_cmd_type      cmd;
   dp_stat_type       dp_stat;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic              csr_wr;

   // Configuration: only the access phase of a write counts; byte-lane
   // bits of the address are ignored, paddr[2] picks the word.
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && (paddr[2] == REG_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // unmapped words read as zero
   assign prdata = (paddr[2] == REG_CAPACITY)
                 ? {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff}
                 : '0;

   // Sequencer: capture, then evaluate when the response slot frees up
   bipbrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (dp_stat),
      .cmd       (cmd)
   );

   // Pointer state and response register
   bipbrc_datapath #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (dp_stat),
      .req_op     (req.op),
      .req_size   (req.size),
      .capacity   (capacity_ff),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_status (rsp.status),
      .rsp_offset (rsp.offset)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the bip buffer region controller: random and directed ops
`timescale 1ns / 100ps

module tb_top;
   import bipbrc_pkg::*;

   // Spare op encodings; the block must flag all of them as misuse
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int OFFSET_MAX   = (1 << OFFSET_BITS_DEFAULT) - 1;
   localparam int PHASES       = 8;
   localparam int RANDOM_ITEMS = 206;      // per phase, ~1650 in total
   localparam int SETTLE_CYCLES = 8;       // capture/evaluate pipeline plus margin
   localparam int CYCLE_LIMIT  = 400000;
   localparam int CLOCK_HALF   = 5;

   // Capacity per phase. Upper bits of the word are junk on purpose, the
   // register only keeps the low 16. Includes both extremes and zero; the
   // last phase gets a random word.
   localparam logic [CSR_DATA_W-1:0] CAPACITY_PLAN [PHASES] = '{
      32'h0000_FFFF, 32'hA5A5_0040, 32'h0000_0001, 32'hFFFF_0000,
      32'h0000_03E8, 32'h5A5A_FFFF, 32'h0000_0011, 32'h0000_0000
   };

   typedef struct {
      status_type              status;
      logic [OFFSET_OUT_W-1:0] offset;
   } reply_type;

   // ------------------------------------------------------------------
   // Scoreboard: tracks region pointers, predicts one reply per request
   // transaction and checks replies in order.
   // ------------------------------------------------------------------
   class region_scoreboard;
      logic [CAP_W-1:0]               capacity;
      logic [OFFSET_BITS_DEFAULT-1:0] region_start [2];
      logic [OFFSET_BITS_DEFAULT-1:0] region_stop [2];
      bit                             rd_sel;
      bit                             wr_sel;
      logic [SIZE_W-1:0]              rd_staged;
      logic [SIZE_W-1:0]              wr_staged;
      reply_type                      awaited [$];
      int                             mismatches;

      function new();
         capacity   = CAPACITY_RESET;
         mismatches = 0;
         empty_regions();
      endfunction

      function void empty_regions();
         region_start[0] = '0;
         region_start[1] = '0;
         region_stop[0]  = '0;
         region_stop[1]  = '0;
         rd_sel    = 1'b0;
         wr_sel    = 1'b0;
         rd_staged = '0;
         wr_staged = '0;
      endfunction

      function void set_capacity(logic [CSR_DATA_W-1:0] word);
         capacity = word[CAP_W-1:0];
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size);
         reply_type exp;
         int     usable;
         int     rb;
         int     re;
         int     we;
         int     avail;
         bit     r;
         bit     w;
         exp.status = ST_MISUSE;
         exp.offset = '0;
         r = rd_sel;
         w = wr_sel;
         usable = (capacity < OFFSET_MAX) ? capacity : OFFSET_MAX;
         rb = region_start[r];
         re = region_stop[r];
         we = region_stop[w];
         // free space ahead of the writer when it sits behind the reader
         avail = (rb == re) ? usable : rb;
         case (op)
            OP_STAGE_READ: if (size != 0 && rd_staged == 0) begin
               if (rb != re) begin
                  if (rb > re || re - rb < size) begin
                     exp.status = ST_REFUSED;
                  end else begin
                     rd_staged  = size;
                     exp.status = ST_OK;
                     exp.offset = OFFSET_OUT_W'(rb);
                  end
               end else if (r == w || region_stop[~r] < size) begin
                  exp.status = ST_REFUSED;
               end else begin
                  // drained: follow the writer into the other region
                  region_start[~r] = '0;
                  rd_sel     = ~r;
                  rd_staged  = size;
                  exp.status = ST_OK;
               end
            end
            OP_COMMIT_READ: if (size != 0 && rd_staged != 0 && size <= rd_staged) begin
               region_start[r] = region_start[r] + size;
               rd_staged  = '0;
               exp.status = ST_OK;
            end
            OP_STAGE_WRITE: if (size != 0 && wr_staged == 0) begin
               if (r == w) begin
                  if (we <= usable && usable - we >= size) begin
                     wr_staged  = size;
                     exp.status = ST_OK;
                     exp.offset = OFFSET_OUT_W'(we);
                  end else if (avail < size) begin
                     exp.status = ST_REFUSED;
                  end else begin
                     // no room at the tail: wrap into the other region
                     region_stop[~w] = '0;
                     wr_sel     = ~w;
                     wr_staged  = size;
                     exp.status = ST_OK;
                  end
               end else if (avail < we || avail - we < size) begin
                  exp.status = ST_REFUSED;
               end else begin
                  wr_staged  = size;
                  exp.status = ST_OK;
                  exp.offset = OFFSET_OUT_W'(we);
               end
            end
            OP_COMMIT_WRITE: if (size != 0 && wr_staged != 0 && size <= wr_staged) begin
               region_stop[w] = region_stop[w] + size;
               wr_staged  = '0;
               exp.status = ST_OK;
            end
            OP_CLEAR: begin
               empty_regions();
               exp.status = ST_OK;
            end
            default: ;
         endcase
         awaited.push_back(exp);
      endfunction

      function void flag(string what);
         if (mismatches < 10)
            $display("[%0t] rsp error: %s", $realtime, what);
         mismatches++;
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [OFFSET_OUT_W-1:0] offset);
         reply_type exp;
         if (awaited.size() == 0) begin
            flag($sformatf("unexpected transaction, status %0d offset %0d", status, offset));
            return;
         end
         exp = awaited.pop_front();
         if (status !== exp.status || offset !== exp.offset)
            flag($sformatf("status exp %0d got %0d, offset exp %0d got %0d",
                           exp.status, status, exp.offset, offset));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bipbrc_req_if req_ch ();
   bipbrc_rsp_if rsp_ch ();

   region_scoreboard sb;
   int               sender_idle_pct;
   int               receiver_stall_pct;
   int               cap_now;
   int unsigned      cycle_count;

   bip_buffer_region_controller dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Cycle counter and watchdog
   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // Response side: values are sampled at the edge, before the block's
   // registers update, so the check sees what the handshake accepted.
   // ready is re-rolled every cycle from the phase's stall rate.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.offset);
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // One request transaction. An optional idle gap goes first; valid is
   // only dropped when a gap is taken, so back-to-back items keep it high.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.size  <= size;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, size);
   endtask

   // APB write: setup cycle, then access until pready
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_capacity(word);
      cap_now = word[CAP_W-1:0];
   endtask

   // Wait for every predicted reply, then let the pipeline settle
   task automatic settle();
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly small spans so the regions fill and wrap; some up to a quarter
   // of capacity, a few anywhere in the 16-bit range.
   function automatic logic [SIZE_W-1:0] span_size(input int span);
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return SIZE_W'($urandom_range(1, 8));
      if (roll < 90) return SIZE_W'($urandom_range(1, span));
      return SIZE_W'($urandom_range(0, OFFSET_MAX));
   endfunction

   // Commit sizes: mostly legal (partial or full), the rest anything
   function automatic logic [SIZE_W-1:0] commit_size(input logic [SIZE_W-1:0] staged);
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return SIZE_W'($urandom_range(1, staged));
      if (roll < 88) return staged;
      return SIZE_W'($urandom_range(0, OFFSET_MAX));
   endfunction

   // Random traffic: stage/commit pairs with random content, plus some
   // clears and loose single ops (spare codes, zero sizes, stray commits).
   task automatic run_traffic(input int n_items);
      int                sent;
      int                roll;
      int                span;
      logic [SIZE_W-1:0] staged;
      sent = 0;
      span = (cap_now > 4) ? cap_now / 4 : 1;
      while (sent < n_items) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            staged = span_size(span);
            send_request(OP_STAGE_WRITE, staged);
            send_request(OP_COMMIT_WRITE, commit_size(staged));
            sent += 2;
         end else if (roll < 80) begin
            staged = span_size(span);
            send_request(OP_STAGE_READ, staged);
            send_request(OP_COMMIT_READ, commit_size(staged));
            sent += 2;
         end else if (roll < 82) begin
            send_request(OP_CLEAR, SIZE_W'($urandom()));
            sent++;
         end else begin
            send_request(OP_W'($urandom_range(7)),
                         ($urandom_range(3) == 0) ? '0 : SIZE_W'($urandom()));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int phase;
      logic [CSR_DATA_W-1:0] cap_word;
      sb = new();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      cap_now            = CAPACITY_RESET;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= OP_STAGE_READ;
      req_ch.size  <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // registers only change with the block idle; region state is kept
         // across phases, so a shrunk capacity meets live pointers
         settle();
         cap_word = (phase == PHASES - 1) ? $urandom() : CAPACITY_PLAN[phase];
         write_capacity(cap_word);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase

         if (phase == 0) begin
            // Directed walk at full capacity from the reset state
            send_request(OP_STAGE_READ, '0);             // zero size
            send_request(OP_STAGE_READ, 16'd1);          // empty, refused
            send_request(OP_COMMIT_READ, 16'd1);         // commit without stage
            send_request(OP_COMMIT_WRITE, 16'd1);        // commit without stage
            send_request(OP_STAGE_WRITE, 16'hFFFF);      // whole store
            send_request(OP_STAGE_WRITE, 16'd1);         // second stage
            send_request(OP_COMMIT_WRITE, '0);           // zero size commit
            send_request(OP_COMMIT_WRITE, 16'hFFFF);     // store full
            send_request(OP_STAGE_WRITE, 16'd1);         // no space, refused
            send_request(OP_STAGE_READ, 16'd100);
            send_request(OP_STAGE_READ, 16'd100);        // second stage
            send_request(OP_COMMIT_READ, 16'd101);       // larger than stage
            send_request(OP_COMMIT_READ, 16'd100);
            send_request(OP_STAGE_WRITE, 16'd50);        // wraps to region 1
            send_request(OP_COMMIT_WRITE, 16'd50);
            send_request(OP_SPARE_5, 16'd1);
            send_request(OP_SPARE_6, 16'h8000);
            send_request(OP_SPARE_7, '0);
            send_request(OP_STAGE_READ, 16'd65435);      // rest of region 0
            send_request(OP_COMMIT_READ, 16'd65435);
            send_request(OP_STAGE_READ, 16'd10);         // reader follows writer
            send_request(OP_COMMIT_READ, 16'd10);
            send_request(OP_STAGE_WRITE, 16'd41);
            send_request(OP_COMMIT_WRITE, 16'd40);       // partial commit
            send_request(OP_CLEAR, 16'hFFFF);            // size ignored
         end

         run_traffic(RANDOM_ITEMS);
         req_ch.valid <= 1'b0;
      end

      settle();
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
